/* hw/rtl/qcws_pkg.sv */
// Shared types and constants for the QUIC connection-id worker steering block.
// No dependencies.
package qcws_pkg;

   localparam int WORKER_BITS_DEFAULT = 16;
   localparam int ID_BITS             = 32;
   localparam int STEP_BITS           = $clog2(ID_BITS);
   localparam int JOB_DEPTH           = 2;   // power of two: pointers wrap naturally
   localparam int JOB_PTR_BITS        = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_BITS        = $clog2(JOB_DEPTH + 1);

   localparam logic [4:0]  MIN_LEN            = 5'd9;
   localparam logic [4:0]  MIN_LONG_LEN       = 5'd14;
   localparam logic [7:0]  LONG_BIT           = 8'h80;
   localparam logic [3:0]  LONG_START         = 4'd6;
   localparam logic [3:0]  SHORT_START        = 4'd1;
   localparam logic [3:0]  ID_BYTES           = 4'd4;
   localparam logic [3:0]  COUNT_MAX          = 4'd15;
   localparam logic [15:0] WORKER_COUNT_RESET = 16'd1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] fallback_worker;
   } req_type;

   typedef struct packed {
      logic [15:0] worker_index;
      logic        used_fallback;
   } rsp_type;

   // One finished packet handed from the front end to the divider.
   typedef struct packed {
      logic                 use_fallback;
      logic [15:0]          fallback_worker;
      logic [ID_BITS-1:0]   id_word;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

/* hw/rtl/qcws_front.sv */
// Front end: walks the payload bytes, gathers the steering word and length class.
// Depends on qcws_pkg.
module qcws_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  qcws_pkg::req_type req_data,
   input  logic              job_full,
   output logic              job_wr,
   output qcws_pkg::job_type job_data
);
   import qcws_pkg::*;

   logic [3:0]         count_ff, count_in;
   logic               long_ff, long_in;
   logic [ID_BITS-1:0] word_ff, word_in;

   logic               accept;
   logic               is_long;
   logic [3:0]         start;
   logic               in_window;
   logic [4:0]         len;
   logic [ID_BITS-1:0] word_next;

   always_comb begin
      accept    = req_push && !job_full;
      is_long   = (count_ff == 4'd0) ? ((req_data.data_byte & LONG_BIT) != 8'd0) : long_ff;
      start     = is_long ? LONG_START : SHORT_START;
      in_window = (count_ff >= start) && (count_ff < start + ID_BYTES);
      word_next = in_window ? {word_ff[ID_BITS-9:0], req_data.data_byte} : word_ff;
      len       = {1'b0, count_ff} + 5'd1;

      job_wr                   = accept && req_data.last_byte;
      job_data.use_fallback    = (len < MIN_LEN) || (is_long && (len < MIN_LONG_LEN));
      job_data.fallback_worker = req_data.fallback_worker;
      job_data.id_word         = word_next;

      count_in = count_ff;
      long_in  = long_ff;
      word_in  = word_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            count_in = 4'd0;
            long_in  = 1'b0;
            word_in  = '0;
         end else begin
            // saturate: anything past fifteen bytes passes every length test
            count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 4'd1;
            long_in  = is_long;
            word_in  = word_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         long_ff  <= 1'b0;
         word_ff  <= '0;
      end else begin
         count_ff <= count_in;
         long_ff  <= long_in;
         word_ff  <= word_in;
      end
   end

endmodule

/* hw/rtl/qcws_job_fifo.sv */
// Short queue of finished packets between the front end and the divider.
// Depends on qcws_pkg.
module qcws_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  qcws_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output qcws_pkg::job_type rd_data,
   output logic              empty
);
   import qcws_pkg::*;

   job_type                 mem_ff [JOB_DEPTH];
   logic [JOB_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    do_wr, do_rd;

   always_comb begin
      full      = (cnt_ff == JOB_CNT_BITS'(JOB_DEPTH));
      empty     = (cnt_ff == '0);
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      rd_data   = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hw/rtl/qcws_back.sv */
// Back end: worker-count register, bit-serial modulo and the result register.
// Depends on qcws_pkg.
module qcws_back #(
   parameter int WORKER_BITS = qcws_pkg::WORKER_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              job_empty,
   input  qcws_pkg::job_type job_data,
   output logic              job_rd,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qcws_pkg::rsp_type rsp_data
);
   import qcws_pkg::*;

   // the register is 16 bits wide, so at most 16 divisor bits ever matter
   localparam int DIV_BITS = (WORKER_BITS < 16) ? WORKER_BITS : 16;

   logic [15:0]          count_ff, count_in;
   back_state_type       state_ff, state_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [ID_BITS-1:0]   word_ff, word_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 fb_ff, fb_in;
   logic [15:0]          fb_val_ff, fb_val_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic [DIV_BITS-1:0]  divisor;
   logic [DIV_BITS:0]    trial;
   logic                 take_job;
   logic                 load_out;
   logic                 last_step;

   assign divisor = count_ff[DIV_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               if (job_data.use_fallback || divisor == '0) begin
                  state_in = BK_DONE;
               end else begin
                  state_in = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            if (step_ff == STEP_BITS'(ID_BITS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      take_job  = 1'b0;
      load_out  = 1'b0;
      last_step = 1'b0;
      case (state_ff)
         BK_IDLE: take_job  = !job_empty;
         BK_DIV:  last_step = (step_ff == STEP_BITS'(ID_BITS - 1));
         BK_DONE: load_out  = !out_valid_ff || rsp_pop;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      count_in  = csr_we ? csr_wdata : count_ff;
      job_rd    = take_job;
      trial     = {rem_ff, word_ff[ID_BITS-1]};
      rem_in    = rem_ff;
      word_in   = word_ff;
      step_in   = step_ff;
      fb_in     = fb_ff;
      fb_val_in = fb_val_ff;

      if (take_job) begin
         rem_in    = '0;
         word_in   = job_data.id_word;
         step_in   = '0;
         fb_in     = job_data.use_fallback;
         fb_val_in = job_data.fallback_worker;
      end else if (state_ff == BK_DIV) begin
         // restoring step: bring in the next dividend bit, subtract if it fits
         rem_in  = (trial >= {1'b0, divisor}) ? DIV_BITS'(trial - {1'b0, divisor})
                                              : trial[DIV_BITS-1:0];
         word_in = {word_ff[ID_BITS-2:0], 1'b0};
         step_in = last_step ? step_ff : step_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load_out) begin
         out_valid_in         = 1'b1;
         out_in.worker_index  = fb_ff ? fb_val_ff : 16'(rem_ff);
         out_in.used_fallback = fb_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      word_ff   <= word_in;
      step_ff   <= step_in;
      fb_val_ff <= fb_val_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= WORKER_COUNT_RESET;
         state_ff     <= BK_IDLE;
         fb_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         state_ff     <= state_in;
         fb_ff        <= fb_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* hw/rtl/quic_cid_worker_steering.sv */
// Top level of the QUIC connection-id worker steering block.
// Depends on qcws_pkg, qcws_front, qcws_job_fifo and qcws_back.
//
//   port group  direction  word
//   req_        in         one payload byte, last flag, fallback index
//   rsp_        out        worker index and fallback flag, one per packet
//   csr_        in         worker count (reset 1)
//
// Bytes are taken one per cycle while the job queue has room.
// A steered packet starts from idle, runs the bit-serial modulo over its
// 32 dividend bits and loads the result register, one packet at a time.
// A fallback packet or a zero worker count skips the modulo.
// Reset is synchronous; rsp_empty is high after it. A held result stalls
// the divider only; the front keeps taking bytes until the queue fills.
module quic_cid_worker_steering #(
   parameter int WORKER_BITS = qcws_pkg::WORKER_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  qcws_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qcws_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import qcws_pkg::*;

   logic    job_wr, job_full, job_rd, job_empty;
   job_type job_in, job_out;

   assign req_full = job_full;

   qcws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .job_full (job_full),
      .job_wr   (job_wr),
      .job_data (job_in)
   );

   qcws_job_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr),
      .wr_data (job_in),
      .full    (job_full),
      .rd_en   (job_rd),
      .rd_data (job_out),
      .empty   (job_empty)
   );

   qcws_back #(
      .WORKER_BITS (WORKER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_empty (job_empty),
      .job_data  (job_out),
      .job_rd    (job_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/qcws_checker.sv */
// Port-level checks for the QUIC connection-id worker steering block, and its bind.
// Depends on qcws_pkg and quic_cid_worker_steering.
module qcws_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input qcws_pkg::req_type req_data,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input qcws_pkg::rsp_type rsp_data,
   input logic              csr_we,
   input logic [15:0]       csr_wdata
);
   import qcws_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [3:0]  pend_ff, pend_in;
   logic        pkt_in, pkt_out;

   // track the worker count and the number of packets still owed a result
   always_comb begin
      pkt_in   = req_push && !req_full && req_data.last_byte;
      pkt_out  = rsp_pop && !rsp_empty;
      count_in = csr_we ? csr_wdata : count_ff;
      pend_in  = pend_ff + {3'd0, pkt_in} - {3'd0, pkt_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= WORKER_COUNT_RESET;
         pend_ff  <= 4'd0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> pend_ff != 4'd0)
      else $error("result without a finished packet");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.used_fallback && count_ff != 16'd0)
         |-> rsp_data.worker_index < count_ff)
      else $error("steered index not below worker count");

   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.used_fallback && count_ff == 16'd0)
         |-> rsp_data.worker_index == 16'd0)
      else $error("zero worker count gave a nonzero index");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule

bind quic_cid_worker_steering qcws_checker u_qcws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);

/* verif/tb_quic_cid_worker_steering.sv */
// Self-checking bench for quic_cid_worker_steering: random packets, stalling receiver.
// Depends on qcws_pkg and the quic_cid_worker_steering RTL.
`timescale 1ns / 100ps

module tb_quic_cid_worker_steering;
   import qcws_pkg::*;

   localparam int SHORT_ID_FIRST = 1;
   localparam int LONG_ID_FIRST  = 6;
   localparam int ID_LEN         = 4;
   localparam int SHORT_MIN_LEN  = 9;
   localparam int LONG_MIN_LEN   = 14;
   localparam int POS_SAT        = 15;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_BYTES    = 140;
   localparam int NUM_PHASES     = 8;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   req_type           req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [15:0]       csr_wdata = '0;

   quic_cid_worker_steering u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // steering state as the block should hold it
   logic [15:0] workers_cfg = 16'd1;
   logic [3:0]  pkt_count   = '0;
   logic        pkt_long    = 1'b0;
   logic [31:0] pkt_id      = '0;

   req_type     pending_bytes_q[$];
   rsp_type     expected_workers_q[$];
   rsp_type     pred_word;
   rsp_type     exp_word;

   int unsigned mismatches     = 0;
   int unsigned bytes_taken    = 0;
   int unsigned fallback_seen  = 0;
   int unsigned steered_seen   = 0;
   int unsigned settings_seen  = 0;

   bit          send_gaps_on   = 1'b0;
   bit          recv_stall_on  = 1'b0;
   logic [15:0] stall_pattern  = '0;
   logic [3:0]  stall_phase    = '0;
   int unsigned burst_left     = 0;
   int unsigned gap_left       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Advance the packet state by one byte; return 1 with the worker word on a last byte.
   function automatic bit steer_byte(input req_type w, output rsp_type r);
      int   pos;
      int   first;
      int   len;
      bit   is_long;
      pos = pkt_count;
      r   = '0;
      if (pos == 0) pkt_long = w.data_byte[7];
      is_long = pkt_long;
      first   = is_long ? LONG_ID_FIRST : SHORT_ID_FIRST;
      if (pos >= first && pos < first + ID_LEN) pkt_id = {pkt_id[23:0], w.data_byte};
      if (pos < POS_SAT) pkt_count = pkt_count + 4'd1;
      if (!w.last_byte) return 1'b0;
      len = pos + 1;
      if (len < SHORT_MIN_LEN || (is_long && len < LONG_MIN_LEN)) begin
         r.worker_index  = w.fallback_worker;
         r.used_fallback = 1'b1;
      end else begin
         r.worker_index  = (workers_cfg == 16'd0) ? 16'd0 : 16'(pkt_id % workers_cfg);
         r.used_fallback = 1'b0;
      end
      pkt_count = '0;
      pkt_long  = 1'b0;
      pkt_id    = '0;
      return 1'b1;
   endfunction

   // id_fill: 0 random bytes, 1 all ones, 2 all zeros (header bit kept)
   task automatic queue_packet(input int len, input bit long_hdr, input int id_fill);
      req_type w;
      for (int i = 0; i < len; i++) begin
         case (id_fill)
            1:       w.data_byte = 8'hFF;
            2:       w.data_byte = 8'h00;
            default: w.data_byte = 8'($urandom_range(0, 255));
         endcase
         if (i == 0) w.data_byte[7] = long_hdr;
         w.last_byte       = (i == len - 1);
         w.fallback_worker = 16'($urandom_range(0, 65535));
         pending_bytes_q.push_back(w);
      end
   endtask

   // Lengths cluster around the short and long thresholds and the counter saturation.
   function automatic int pick_len();
      case ($urandom_range(0, 9))
         0:       return 1;
         1:       return $urandom_range(2, 8);
         2:       return 13;
         3:       return 14;
         4:       return 15;
         5:       return 16;
         6:       return $urandom_range(17, 40);
         default: return $urandom_range(9, 20);
      endcase
   endfunction

   task automatic fill_phase(input int byte_budget);
      int queued;
      int id_fill;
      queued = 0;
      while (queued < byte_budget) begin
         id_fill = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
         queue_packet(pick_len(), 1'($urandom_range(0, 1)), id_fill);
         queued = pending_bytes_q.size();
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes_q.size() != 0 || req_push || expected_workers_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_workers(input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      workers_cfg = value;
      @(negedge clock);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_bytes_q.size() != 0) begin
            req_data <= pending_bytes_q.pop_front();
            req_push <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = (!send_gaps_on || $urandom_range(0, 3) == 0) ? 0 :
                            $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: stall on a rotating per-phase pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop     <= !(recv_stall_on && stall_pattern[stall_phase]);
         stall_phase <= stall_phase + 4'd1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         bytes_taken = bytes_taken + 1;
         if (steer_byte(req_data, pred_word)) expected_workers_q.push_back(pred_word);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_workers_q.size() == 0) begin
            $display("%0t: unexpected word worker_index=%h used_fallback=%b",
                     $time, rsp_data.worker_index, rsp_data.used_fallback);
            mismatches = mismatches + 1;
         end else begin
            exp_word = expected_workers_q.pop_front();
            if (exp_word.used_fallback) fallback_seen = fallback_seen + 1;
            else steered_seen = steered_seen + 1;
            if (rsp_data.worker_index !== exp_word.worker_index) begin
               $display("%0t: worker_index expected %h actual %h",
                        $time, exp_word.worker_index, rsp_data.worker_index);
               mismatches = mismatches + 1;
            end
            if (rsp_data.used_fallback !== exp_word.used_fallback) begin
               $display("%0t: used_fallback expected %b actual %b",
                        $time, exp_word.used_fallback, rsp_data.used_fallback);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   initial begin
      logic [15:0] phase_workers[NUM_PHASES];
      phase_workers = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd3, 16'h8000,
                        16'd1, 16'd7};
      phase_workers[6] = 16'($urandom_range(1, 65535));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // phase 0 runs on the reset count of one
         if (ph != 0) write_workers(phase_workers[ph]);
         settings_seen = settings_seen + 1;
         send_gaps_on  = (ph % 3) != 1;
         recv_stall_on = (ph % 4) != 2;
         stall_pattern = 16'($urandom_range(0, 65535)) & 16'h7FFF;
         if (ph == 0) begin
            // single byte, minimal short packet, minimal long packet
            queue_packet(1, 1'b1, 1);
            queue_packet(SHORT_MIN_LEN, 1'b0, 1);
            queue_packet(LONG_MIN_LEN, 1'b1, 1);
         end
         fill_phase(PHASE_BYTES);
         wait_drained();
      end

      $display("Took %0d bytes over %0d worker-count settings (zero and 65535 among them);",
               bytes_taken, settings_seen);
      $display("checked %0d steered and %0d fallback words, %0d mismatches.",
               steered_seen, fallback_seen, mismatches);
      if (mismatches == 0 && expected_workers_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/qcws_pkg.sv
hw/rtl/qcws_front.sv
hw/rtl/qcws_job_fifo.sv
hw/rtl/qcws_back.sv
hw/rtl/quic_cid_worker_steering.sv
hw/rtl/qcws_checker.sv
verif/tb_quic_cid_worker_steering.sv
